// File: rtl/cfa_pkg.sv
// cfa_pkg: shared types, field widths and codes of the contiguous fit allocator.
// No dependencies; imported by the interfaces and every module.
`default_nettype none

package cfa_pkg;

  localparam int MEM_UNITS_DEF = 32;

  localparam int OP_W     = 1;
  localparam int SIZE_W   = 6;
  localparam int OWNER_W  = 8;
  localparam int STATUS_W = 2;
  localparam int START_W  = 5;
  localparam int LENGTH_W = 6;
  localparam int POL_W    = 2;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_HOLE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_OWNER = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SIZE_W-1:0]  request_size;
    logic [OWNER_W-1:0] owner_id;
  } cfa_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  seg_start;
    logic [LENGTH_W-1:0] seg_length;
  } cfa_rsp_t;

  typedef struct packed {
    logic               used;
    logic               head;
    logic [OWNER_W-1:0] owner;
  } cfa_entry_t;

endpackage

`default_nettype wire

// File: rtl/cfa_if.sv
// cfa_req_if / cfa_rsp_if: valid/ready channels for request and result words.
// Depends on cfa_pkg.
`default_nettype none

interface cfa_req_if
  import cfa_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [SIZE_W-1:0]  request_size;
  logic [OWNER_W-1:0] owner_id;

  modport source (output valid, output op, output request_size, output owner_id,
                  input ready);
  modport sink   (input valid, input op, input request_size, input owner_id,
                  output ready);
endinterface

interface cfa_rsp_if
  import cfa_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  seg_start;
  logic [LENGTH_W-1:0] seg_length;

  modport source (output valid, output status, output seg_start, output seg_length,
                  input ready);
  modport sink   (input valid, input status, input seg_start, input seg_length,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/contiguous_fit_allocator_unit.sv
// contiguous_fit_allocator_unit: top level; policy register, engine, result register.
// Depends on cfa_pkg, cfa_if and cfa_engine.
//
//   channel   dir  handshake     word
//   in_req    in   valid/ready   op, request_size, owner_id
//   out_rsp   out  valid/ready   status, seg_start, seg_length
//   cfg_*     in   cfg_we        fit_policy
//
// Allocate scans all units, then writes request_size units on success; free stops at the
// segment's end. Both scans are set by the one-unit-per-cycle read port of the unit map.
// After reset a clearing pass over all MEM_UNITS units runs with in_req.ready low.
// One word at a time; the next is taken while the last result waits in out_rsp.
`default_nettype none

module contiguous_fit_allocator_unit
  import cfa_pkg::*;
#(
  parameter int MEM_UNITS = MEM_UNITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [POL_W-1:0] cfg_wdata,
  cfa_req_if.sink               in_req,
  cfa_rsp_if.source             out_rsp
);

  logic [POL_W-1:0] policy_r;
  logic             out_valid_r;
  cfa_rsp_t         out_data_r;
  cfa_req_t         req;
  logic             res_valid;
  logic             res_ready;
  cfa_rsp_t         res;

  assign req.op           = in_req.op;
  assign req.request_size = in_req.request_size;
  assign req.owner_id     = in_req.owner_id;

  assign res_ready = !out_valid_r || out_rsp.ready;

  cfa_engine #(.MEM_UNITS(MEM_UNITS)) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .fit_policy (policy_r),
    .req_valid  (in_req.valid),
    .req_ready  (in_req.ready),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POL_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
      if (res_ready) begin
        out_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_data_r.status;
  assign out_rsp.seg_start  = out_data_r.seg_start;
  assign out_rsp.seg_length = out_data_r.seg_length;

endmodule

`default_nettype wire

// File: rtl/cfa_fit_cmp.sv
// cfa_fit_cmp: hole compare unit; decides whether a closed hole replaces the pick.
// Depends on cfa_pkg.
`default_nettype none

module cfa_fit_cmp
  import cfa_pkg::*;
#(
  parameter int L_W = 6
) (
  input  wire logic [POL_W-1:0]  fit_policy,
  input  wire logic [SIZE_W-1:0] req_size,
  input  wire logic [L_W-1:0]    hole_len,
  input  wire logic [L_W-1:0]    pick_len,
  input  wire logic              found,
  output logic                   take
);

  localparam int CW = (L_W > SIZE_W) ? L_W : SIZE_W;

  logic fits;

  assign fits = (req_size != '0) && (CW'(hole_len) >= CW'(req_size));

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found) begin
        take = 1'b1;
      end else begin
        unique case (fit_policy)
          POL_BEST:  take = (hole_len < pick_len);
          POL_WORST: take = (hole_len > pick_len);
          default:   take = 1'b0;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/cfa_engine.sv
// cfa_engine: unit map memory and the sequencer that clears, scans and writes it.
// Depends on cfa_pkg and cfa_fit_cmp.
`default_nettype none

module cfa_engine
  import cfa_pkg::*;
#(
  parameter int MEM_UNITS = MEM_UNITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [POL_W-1:0] fit_policy,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire cfa_req_t         req,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output cfa_rsp_t              res
);

  localparam int A_W = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
  localparam int L_W = $clog2(MEM_UNITS + 1);
  localparam logic [A_W-1:0] LAST = A_W'(MEM_UNITS - 1);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  cfa_entry_t mem [MEM_UNITS];

  logic [2:0]         state_r, state_nxt;
  logic [A_W-1:0]     scan_addr_r, scan_addr_nxt;
  logic               issue_r, issue_nxt;
  logic               rd_vld_r;
  logic [A_W-1:0]     rd_addr_r;
  cfa_entry_t         rd_data_r;
  logic               rd_en;
  cfa_req_t           req_r, req_nxt;
  logic               found_r, found_nxt;
  logic [A_W-1:0]     pick_start_r, pick_start_nxt;
  logic [L_W-1:0]     pick_len_r, pick_len_nxt;
  logic [A_W-1:0]     hole_start_r, hole_start_nxt;
  logic [L_W-1:0]     hole_len_r, hole_len_nxt;
  logic [SIZE_W-1:0]  cnt_r, cnt_nxt;
  cfa_rsp_t           res_r, res_nxt;

  logic               we;
  logic [A_W-1:0]     wa;
  cfa_entry_t         wd;

  logic               ev_en;
  logic [A_W-1:0]     ev_start;
  logic [L_W-1:0]     ev_len;
  logic               take;
  logic [L_W-1:0]     cur_len;
  logic [A_W-1:0]     cur_start;
  logic               last_rd;
  logic               owner_hit;

  function automatic logic [L_W-1:0] cur_len_free(input logic [L_W-1:0] n);
    cur_len_free = L_W'(n + 1'b1);
  endfunction

  cfa_fit_cmp #(.L_W(L_W)) u_fit_cmp (
    .fit_policy (fit_policy),
    .req_size   (req_r.request_size),
    .hole_len   (ev_len),
    .pick_len   (pick_len_r),
    .found      (found_r),
    .take       (take)
  );

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;
  assign rd_en     = (state_r == S_SCAN) && issue_r;
  assign last_rd   = (rd_addr_r == LAST);
  assign cur_len   = L_W'(hole_len_r + 1'b1);
  assign cur_start = (hole_len_r == '0) ? rd_addr_r : hole_start_r;
  assign owner_hit = rd_data_r.used && rd_data_r.head && (rd_data_r.owner == req_r.owner_id);

  always_comb begin
    ev_en    = 1'b0;
    ev_start = hole_start_r;
    ev_len   = hole_len_r;
    if (state_r == S_SCAN && rd_vld_r && req_r.op == OP_ALLOC) begin
      if (!rd_data_r.used) begin
        ev_en    = last_rd;
        ev_start = cur_start;
        ev_len   = cur_len;
      end else begin
        ev_en = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    scan_addr_nxt  = scan_addr_r;
    issue_nxt      = issue_r;
    req_nxt        = req_r;
    found_nxt      = found_r;
    pick_start_nxt = pick_start_r;
    pick_len_nxt   = pick_len_r;
    hole_start_nxt = hole_start_r;
    hole_len_nxt   = hole_len_r;
    cnt_nxt        = cnt_r;
    res_nxt        = res_r;
    we             = 1'b0;
    wa             = scan_addr_r;
    wd             = '0;

    unique case (state_r)
      S_CLR: begin
        we = 1'b1;
        if (scan_addr_r == LAST) begin
          state_nxt = S_IDLE;
        end else begin
          scan_addr_nxt = scan_addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          req_nxt        = req;
          state_nxt      = S_SCAN;
          scan_addr_nxt  = '0;
          issue_nxt      = 1'b1;
          found_nxt      = 1'b0;
          pick_start_nxt = '0;
          pick_len_nxt   = '0;
          hole_start_nxt = '0;
          hole_len_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (issue_r) begin
          if (scan_addr_r == LAST) begin
            issue_nxt = 1'b0;
          end else begin
            scan_addr_nxt = scan_addr_r + 1'b1;
          end
        end
        if (rd_vld_r) begin
          if (req_r.op == OP_ALLOC) begin
            if (!rd_data_r.used) begin
              hole_start_nxt = cur_start;
              hole_len_nxt   = cur_len;
            end else begin
              hole_len_nxt = '0;
            end
            if (ev_en && take) begin
              found_nxt      = 1'b1;
              pick_start_nxt = ev_start;
              pick_len_nxt   = ev_len;
            end
            if (last_rd) begin
              if (found_nxt) begin
                state_nxt = S_WRITE;
                cnt_nxt   = '0;
              end else begin
                state_nxt = S_DONE;
                res_nxt   = '{status: ST_NO_HOLE, seg_start: '0, seg_length: '0};
              end
            end
          end else begin
            // free: find owner's head and clear it, then clear its tail units
            wa = rd_addr_r;
            if (!found_r) begin
              if (owner_hit) begin
                we             = 1'b1;
                found_nxt      = 1'b1;
                pick_start_nxt = rd_addr_r;
                pick_len_nxt   = L_W'(1);
              end
              if (last_rd) begin
                state_nxt = S_DONE;
                issue_nxt = 1'b0;
                if (owner_hit) begin
                  res_nxt = '{status: ST_DONE, seg_start: START_W'(rd_addr_r),
                              seg_length: LENGTH_W'(1)};
                end else begin
                  res_nxt = '{status: ST_NO_OWNER, seg_start: '0, seg_length: '0};
                end
              end
            end else if (rd_data_r.used && !rd_data_r.head) begin
              we           = 1'b1;
              pick_len_nxt = cur_len_free(pick_len_r);
              if (last_rd) begin
                state_nxt = S_DONE;
                issue_nxt = 1'b0;
                res_nxt   = '{status: ST_DONE, seg_start: START_W'(pick_start_r),
                              seg_length: LENGTH_W'(pick_len_nxt)};
              end
            end else begin
              state_nxt = S_DONE;
              issue_nxt = 1'b0;
              res_nxt   = '{status: ST_DONE, seg_start: START_W'(pick_start_r),
                            seg_length: LENGTH_W'(pick_len_r)};
            end
          end
        end
      end
      S_WRITE: begin
        we       = 1'b1;
        wa       = A_W'(pick_start_r + A_W'(cnt_r));
        wd.used  = 1'b1;
        wd.head  = (cnt_r == '0);
        wd.owner = req_r.owner_id;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == SIZE_W'(req_r.request_size - 1'b1)) begin
          state_nxt = S_DONE;
          res_nxt   = '{status: ST_DONE, seg_start: START_W'(pick_start_r),
                        seg_length: req_r.request_size};
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[scan_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      scan_addr_r <= '0;
      issue_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_addr_r <= scan_addr_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= rd_en;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r    <= scan_addr_r;
    req_r        <= req_nxt;
    pick_start_r <= pick_start_nxt;
    pick_len_r   <= pick_len_nxt;
    hole_start_r <= hole_start_nxt;
    hole_len_r   <= hole_len_nxt;
    cnt_r        <= cnt_nxt;
    res_r        <= res_nxt;
  end

endmodule

`default_nettype wire
